>>> design/sndu_pkg.sv
// Package: widths, codes, defaults and fixed constants for the SOM neuron.
`timescale 1ns / 1ps
`default_nettype none
package sndu_pkg;

    localparam int MODE_W       = 2;
    localparam int IDX_W        = 4;
    localparam int SAMPLE_W     = 16;
    localparam int ND_W         = 8;
    localparam int DOT_W        = 36;
    localparam int DIST_W       = 19;
    localparam int DACC_W       = 37;
    localparam int VL_W         = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int MUL_W        = 33;

    localparam int DEFAULT_MAX_INPUTS = 16;

    localparam logic [VL_W-1:0]       VL_RESET = 5'd16;
    localparam logic [CFG_DATA_W-1:0] LR_RESET = 16'd6554;
    localparam logic [CFG_DATA_W-1:0] NW_RESET = 16'd256;

    // ceil(2^21 / 6): exact quotient for dividends below 2^19
    localparam logic [18:0] RECIP6   = 19'd349526;
    // gain is zero from t = 12.0 (Q16) upward
    localparam logic [19:0] T_LIMIT  = 20'd786432;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE  = 2'd0,
        MODE_EVAL   = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VECTOR_LENGTH  = 2'd0,
        CFG_LEARN_RATE     = 2'd1,
        CFG_NEIGHBOR_WIDTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sndu_sqrt_stat_t;

endpackage
`default_nettype wire

>>> design/sndu_if.sv
// Interfaces: sample, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface sndu_sample_if import sndu_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [IDX_W-1:0]           element_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [ND_W-1:0]            neighbor_distance;

    modport source (output valid, mode, element_index, sample_value, neighbor_distance,
                    input ready);
    modport sink (input valid, mode, element_index, sample_value, neighbor_distance,
                  output ready);
endinterface

interface sndu_result_if import sndu_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [DOT_W-1:0]    dot_product;
    logic [DIST_W-1:0]          distance;
    logic signed [SAMPLE_W-1:0] weight_value;

    modport source (output valid, dot_product, distance, weight_value, input ready);
    modport sink (input valid, dot_product, distance, weight_value, output ready);
endinterface

interface sndu_cfg_if import sndu_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/sndu_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sndu_sqrt import sndu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DACC_W-1:0] radicand,
    output sndu_sqrt_stat_t        stat,
    output logic [DIST_W-1:0]      root
);

    logic [DACC_W-1:0] v_reg,   v_next;
    logic [DACC_W-1:0] r_reg,   r_next;
    logic [DACC_W-1:0] bit_reg, bit_next;
    logic              done_reg, done_next;
    logic [DACC_W:0]   trial;

    always_comb
    begin
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next   = radicand;
            r_next   = '0;
            bit_next = {1'b1, {(DACC_W-1){1'b0}}};
        end
        else if (bit_reg != '0)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next = v_reg - trial[DACC_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            done_next = bit_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
    end

    assign stat.busy = (bit_reg != '0);
    assign stat.done = done_reg;
    assign root      = r_reg[DIST_W-1:0];

endmodule
`default_nettype wire

>>> design/som_neuron_distance_update.sv
// Top level: SOM neuron with weight store, shared multiplier and sequencer.
//
//  channel | dir | transfer when         | payload
//  sample  | in  | valid && ready        | mode, element_index, sample_value, neighbor_distance
//  result  | out | valid && ready        | dot_product, distance, weight_value
//  cfg     | in  | valid && ready        | index, data (ready is always high)
//
//  Evaluate finishes the last element with the bit-serial root. Update is set by
//  the 21-step divider and eight squarings through the one 33x33 multiplier;
//  on zero gain the series and the squarings are skipped.
//  Reset clears control and accumulators; the weight memory is not cleared.
//  A held result stalls the sequencer once the next result waits to emit; until then samples are taken.
`timescale 1ns / 1ps
`default_nettype none
module som_neuron_distance_update import sndu_pkg::*;
#(
    parameter int MAX_INPUTS = DEFAULT_MAX_INPUTS
)
(
    input wire logic     clk,
    input wire logic     rst_n,
    sndu_sample_if.sink  sample,
    sndu_result_if.source result,
    sndu_cfg_if.sink     cfg
);

    localparam int IW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int LMAX = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_EMIT,
        ST_M1_DOT, ST_M1_DIF, ST_M1_ACC, ST_SQ_WAIT,
        ST_M2_D2, ST_M2_S2, ST_M2_DIVI, ST_M2_DIV,
        ST_M2_U2, ST_M2_U3, ST_M2_U6, ST_M2_Y,
        ST_M2_SQR, ST_M2_SQW, ST_M2_G, ST_M2_K, ST_M2_W
    } state_t;

    // configuration
    logic [VL_W-1:0]       vector_length_reg;
    logic [CFG_DATA_W-1:0] learn_rate_reg;
    logic [CFG_DATA_W-1:0] neighbor_width_reg;

    state_t state_reg;

    logic [MODE_W-1:0]          mode_reg;
    logic [IW-1:0]              addr_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [ND_W-1:0]            nd_reg;
    logic                       last_reg;

    logic signed [DOT_W-1:0]    dot_acc_reg;
    logic [DACC_W-1:0]          dist_acc_reg;

    logic signed [DOT_W-1:0]    res_dot_reg;
    logic [DIST_W-1:0]          res_dist_reg;
    logic signed [SAMPLE_W-1:0] res_w_reg;

    logic                       out_valid_reg;
    logic signed [DOT_W-1:0]    out_dot_reg;
    logic [DIST_W-1:0]          out_dist_reg;
    logic signed [SAMPLE_W-1:0] out_w_reg;

    logic [15:0]  dsq_reg;
    logic [46:0]  rem_reg;
    logic [51:0]  dvs_reg;
    logic [20:0]  q_reg;
    logic [4:0]   div_cnt_reg;
    logic [21:0]  u2_reg;
    logic [30:0]  y_reg;
    logic [2:0]   sq_cnt_reg;

    // weight memory
    logic signed [SAMPLE_W-1:0] mem [MAX_INPUTS];
    logic signed [SAMPLE_W-1:0] w_rd_reg;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;

    logic                  sample_acc;
    logic [VL_W-1:0]       len;
    logic                  idx_ok;
    logic [IW-1:0]         in_addr;
    logic                  out_free;

    logic signed [SAMPLE_W:0]  diff;
    logic                      diff_neg;
    logic [SAMPLE_W:0]         diff_mag;
    logic [CFG_DATA_W-1:0]     sigma;
    logic [25:0]               u;
    logic [DOT_W:0]            dot_sum;
    logic signed [DOT_W-1:0]   dot_sat;
    logic [DACC_W:0]           dist_sum;
    logic [DACC_W-1:0]         dist_sat;
    logic                      div_ge;
    logic [20:0]               q_new;
    logic [31:0]               y_init;
    logic [62:0]               y_sq_rnd;
    logic [16:0]               gain;
    logic [33:0]               k_rnd;
    logic [33:0]               r_rnd;
    logic signed [SAMPLE_W+1:0] nw_wide;
    logic signed [SAMPLE_W-1:0] nw_sat;
    logic                      sqrt_start;
    sndu_sqrt_stat_t           sqrt_stat;
    logic [DIST_W-1:0]         sqrt_root;

    assign len = (vector_length_reg == '0) ? VL_W'(1)
               : ((vector_length_reg > VL_W'(LMAX)) ? VL_W'(LMAX) : vector_length_reg);
    assign idx_ok     = ({1'b0, sample.element_index} < len);
    assign in_addr    = IW'(sample.element_index);
    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_acc = sample.valid && sample.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    assign diff     = (SAMPLE_W+1)'(x_reg) - (SAMPLE_W+1)'(w_rd_reg);
    assign diff_neg = diff[SAMPLE_W];
    assign diff_mag = diff_neg ? (SAMPLE_W+1)'(-diff) : diff;
    assign sigma    = (neighbor_width_reg == '0) ? CFG_DATA_W'(1) : neighbor_width_reg;
    assign u        = {q_reg[19:0], 6'b0};

    assign dot_sum = (DOT_W+1)'(dot_acc_reg) + (DOT_W+1)'(signed'(prod_reg[31:0]));
    assign dot_sat = (dot_sum[DOT_W] != dot_sum[DOT_W-1])
                   ? (dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}})
                   : dot_sum[DOT_W-1:0];
    assign dist_sum = {1'b0, dist_acc_reg} + (DACC_W+1)'(prod_reg[34:0]);
    assign dist_sat = dist_sum[DACC_W] ? {DACC_W{1'b1}} : dist_sum[DACC_W-1:0];

    assign div_ge = ({5'b0, rem_reg} >= dvs_reg);
    assign q_new  = {q_reg[19:0], div_ge};

    assign y_init   = 32'h4000_0000 - 32'(u) + 32'(u2_reg >> 1) - 32'(prod_reg[36:21]);
    assign y_sq_rnd = prod_reg[62:0] + 63'h2000_0000;
    assign gain     = 17'((32'(y_reg) + 32'h2000) >> 14);
    assign k_rnd    = prod_reg[33:0] + 34'h8000;
    assign r_rnd    = prod_reg[33:0] + 34'h8000;
    assign nw_wide  = diff_neg ? (SAMPLE_W+2)'(w_rd_reg) - (SAMPLE_W+2)'(r_rnd[33:16])
                               : (SAMPLE_W+2)'(w_rd_reg) + (SAMPLE_W+2)'(r_rnd[33:16]);
    assign nw_sat   = (nw_wide > 18'sd32767) ? 16'sh7FFF
                    : ((nw_wide < -18'sd32768) ? 16'sh8000 : nw_wide[SAMPLE_W-1:0]);

    assign sqrt_start = (state_reg == ST_M1_ACC) && last_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_M1_DOT:
            begin
                mul_a = MUL_W'(w_rd_reg);
                mul_b = MUL_W'(x_reg);
            end
            ST_M1_DIF:
            begin
                mul_a = MUL_W'(diff);
                mul_b = MUL_W'(diff);
            end
            ST_M2_D2:
            begin
                mul_a = MUL_W'(nd_reg);
                mul_b = MUL_W'(nd_reg);
            end
            ST_M2_S2:
            begin
                mul_a = MUL_W'(sigma);
                mul_b = MUL_W'(sigma);
            end
            ST_M2_U2:
            begin
                mul_a = MUL_W'(u);
                mul_b = MUL_W'(u);
            end
            ST_M2_U3:
            begin
                mul_a = MUL_W'(prod_reg[51:30]);
                mul_b = MUL_W'(u);
            end
            ST_M2_U6:
            begin
                mul_a = MUL_W'(prod_reg[47:30]);
                mul_b = MUL_W'(RECIP6);
            end
            ST_M2_SQR:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_M2_G:
            begin
                mul_a = MUL_W'(learn_rate_reg);
                mul_b = MUL_W'(gain);
            end
            ST_M2_K:
            begin
                mul_a = MUL_W'(diff_mag);
                mul_b = MUL_W'(k_rnd[31:16]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign mem_we    = (sample_acc && idx_ok && (sample.mode == MODE_WRITE))
                     || (state_reg == ST_M2_W);
    assign mem_waddr = (state_reg == ST_M2_W) ? addr_reg : in_addr;
    assign mem_wdata = (state_reg == ST_M2_W) ? nw_sat : sample.sample_value;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (sample_acc)
            w_rd_reg <= mem[in_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg  <= VL_RESET;
            learn_rate_reg     <= LR_RESET;
            neighbor_width_reg <= NW_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_VECTOR_LENGTH:  vector_length_reg  <= cfg.data[VL_W-1:0];
                CFG_LEARN_RATE:     learn_rate_reg     <= cfg.data;
                CFG_NEIGHBOR_WIDTH: neighbor_width_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    // payload, result and update working registers
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            mode_reg <= sample.mode;
            addr_reg <= in_addr;
            x_reg    <= sample.sample_value;
            nd_reg   <= sample.neighbor_distance;
            last_reg <= ({1'b0, sample.element_index} == (len - VL_W'(1)));
        end
        unique case (state_reg)
            ST_RD:
            begin
                res_dot_reg  <= '0;
                res_dist_reg <= '0;
                res_w_reg    <= (mode_reg == MODE_READ) ? w_rd_reg : '0;
            end
            ST_M1_ACC:
                res_dot_reg <= dot_acc_reg;
            ST_SQ_WAIT:
                res_dist_reg <= sqrt_root;
            ST_M2_S2:
                dsq_reg <= prod_reg[15:0];
            ST_M2_DIVI:
            begin
                rem_reg     <= {dsq_reg, 31'b0};
                dvs_reg     <= {prod_reg[31:0], 20'b0};
                q_reg       <= '0;
                div_cnt_reg <= 5'd20;
            end
            ST_M2_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_reg - dvs_reg[46:0];
                dvs_reg     <= dvs_reg >> 1;
                q_reg       <= q_new;
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if ((div_cnt_reg == '0) && (q_new[20] || (q_new[19:0] >= T_LIMIT)))
                    y_reg <= '0;
            end
            ST_M2_U3:
                u2_reg <= prod_reg[51:30];
            ST_M2_Y:
            begin
                y_reg      <= y_init[30:0];
                sq_cnt_reg <= '0;
            end
            ST_M2_SQW:
            begin
                y_reg      <= y_sq_rnd[60:30];
                sq_cnt_reg <= sq_cnt_reg + 3'd1;
            end
            default: ;
        endcase
    end

    // sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dot_acc_reg   <= '0;
            dist_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in ST_EMIT the output register is reloaded below instead
            if (out_valid_reg && result.ready && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (sample_acc && idx_ok && (sample.mode != MODE_WRITE))
                        state_reg <= ST_RD;
                ST_RD:
                begin
                    unique case (mode_reg)
                        MODE_READ:   state_reg <= ST_EMIT;
                        MODE_EVAL:   state_reg <= ST_M1_DOT;
                        MODE_UPDATE: state_reg <= ST_M2_D2;
                        default:     state_reg <= ST_IDLE;
                    endcase
                end
                ST_M1_DOT: state_reg <= ST_M1_DIF;
                ST_M1_DIF:
                begin
                    dot_acc_reg <= dot_sat;
                    state_reg   <= ST_M1_ACC;
                end
                ST_M1_ACC:
                begin
                    if (last_reg)
                    begin
                        dot_acc_reg  <= '0;
                        dist_acc_reg <= '0;
                        state_reg    <= ST_SQ_WAIT;
                    end
                    else
                    begin
                        dist_acc_reg <= dist_sat;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_SQ_WAIT:
                    if (sqrt_stat.done)
                        state_reg <= ST_EMIT;
                ST_EMIT:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dot_reg   <= res_dot_reg;
                        out_dist_reg  <= res_dist_reg;
                        out_w_reg     <= res_w_reg;
                        state_reg     <= ST_IDLE;
                    end
                ST_M2_D2:   state_reg <= ST_M2_S2;
                ST_M2_S2:   state_reg <= ST_M2_DIVI;
                ST_M2_DIVI: state_reg <= ST_M2_DIV;
                ST_M2_DIV:
                    if (div_cnt_reg == '0)
                        state_reg <= (q_new[20] || (q_new[19:0] >= T_LIMIT))
                                   ? ST_M2_G : ST_M2_U2;
                ST_M2_U2:   state_reg <= ST_M2_U3;
                ST_M2_U3:   state_reg <= ST_M2_U6;
                ST_M2_U6:   state_reg <= ST_M2_Y;
                ST_M2_Y:    state_reg <= ST_M2_SQR;
                ST_M2_SQR:  state_reg <= ST_M2_SQW;
                ST_M2_SQW:  state_reg <= (sq_cnt_reg == 3'd7) ? ST_M2_G : ST_M2_SQR;
                ST_M2_G:    state_reg <= ST_M2_K;
                ST_M2_K:    state_reg <= ST_M2_W;
                ST_M2_W:    state_reg <= ST_IDLE;
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    sndu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (dist_sat),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    assign result.valid        = out_valid_reg;
    assign result.dot_product  = out_dot_reg;
    assign result.distance     = out_dist_reg;
    assign result.weight_value = out_w_reg;

endmodule
`default_nettype wire

>>> design/sndu_checker.sv
// Port checker for the SOM neuron, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sndu_checker import sndu_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       sample_ready,
    input wire logic                       result_valid,
    input wire logic                       result_ready,
    input wire logic signed [DOT_W-1:0]    dot_product,
    input wire logic [DIST_W-1:0]          distance,
    input wire logic signed [SAMPLE_W-1:0] weight_value
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(dot_product)
            && $stable(distance) && $stable(weight_value))
        else $error("stalled result changed");

    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (weight_value == '0) || ((dot_product == '0) && (distance == '0)))
        else $error("result mixes evaluate and read fields");

    a_distance_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (distance <= 19'd370727))
        else $error("distance above root of accumulator range");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result appeared without the sequencer running");

endmodule

bind som_neuron_distance_update sndu_checker u_sndu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .dot_product  (result.dot_product),
    .distance     (result.distance),
    .weight_value (result.weight_value)
);
`default_nettype wire
